FILE: src/aet_pkg.sv
// Package: shared types and constants for the arithmetic expression tokenizer.
`timescale 1ns / 1ps

package aet_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int COLUMN_BITS = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        KIND_OBR = 3'd0,
        KIND_CBR = 3'd1,
        KIND_OPR = 3'd2,
        KIND_INT = 3'd3,
        KIND_INV = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_string;
    } item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [VALUE_BITS-1:0]  token_value;
        logic [COLUMN_BITS-1:0] column;
        logic                   overflow;
        logic                   last_of_run;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

endpackage

FILE: src/aet_lexer.sv
// Lexer stage: input register, digit-run state and token generation.
`timescale 1ns / 1ps

module aet_lexer
    import aet_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    input  logic  space_ok,
    output push_t push
);

    item_t                  item_reg;
    logic                   full_reg;
    logic                   in_number_reg,  in_number_next;
    logic [VALUE_BITS-1:0]  accum_reg,      accum_next;
    logic                   ovf_reg,        ovf_next;
    logic [COLUMN_BITS-1:0] start_reg,      start_next;
    logic [COLUMN_BITS-1:0] col_reg,        col_next;

    logic                   proc;
    logic                   digit;
    logic                   makes;
    logic [7:0]             diff;
    logic [VALUE_BITS-1:0]  base;
    logic [VALUE_BITS+3:0]  wide;
    logic                   base_ovf;
    logic                   sat;
    logic [VALUE_BITS-1:0]  new_accum;
    logic                   new_ovf;
    logic [COLUMN_BITS-1:0] new_start;
    kind_t                  ch_kind;
    token_t                 int_tok;
    token_t                 new_tok;
    token_t                 chr_tok;

    assign proc       = full_reg && space_ok;
    assign item_ready = !full_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            full_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
    end

    always_comb
    begin
        digit = item_reg.ch inside {[CH_ZERO:CH_NINE]};
        diff  = item_reg.ch - CH_ZERO;
        makes = item_reg.ch != CH_SPACE;

        base      = in_number_reg ? accum_reg : '0;
        base_ovf  = in_number_reg ? ovf_reg : 1'b0;
        new_start = in_number_reg ? start_reg : col_reg;
        wide      = ({4'b0, base} << 3) + ({4'b0, base} << 1)
                  + {{VALUE_BITS{1'b0}}, diff[3:0]};
        sat       = wide[VALUE_BITS+3:VALUE_BITS] != 4'b0;
        new_accum = sat ? {VALUE_BITS{1'b1}} : wide[VALUE_BITS-1:0];
        new_ovf   = base_ovf || sat;

        case (item_reg.ch)
            CH_OPEN:  ch_kind = KIND_OBR;
            CH_CLOSE: ch_kind = KIND_CBR;
            CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR: ch_kind = KIND_OPR;
            default:  ch_kind = KIND_INV;
        endcase

        int_tok = '{kind: KIND_INT, token_value: accum_reg, column: start_reg,
                    overflow: ovf_reg, last_of_run: 1'b0};
        new_tok = '{kind: KIND_INT, token_value: new_accum, column: new_start,
                    overflow: new_ovf, last_of_run: 1'b0};
        chr_tok = '{kind: ch_kind,
                    token_value: {{(VALUE_BITS-8){1'b0}}, item_reg.ch},
                    column: col_reg, overflow: 1'b0, last_of_run: 1'b0};

        push.count = 2'd0;
        push.tok0  = chr_tok;
        push.tok1  = chr_tok;
        if (digit)
        begin
            if (item_reg.end_of_string)
            begin
                push.tok0  = new_tok;
                push.count = 2'd1;
            end
        end
        else if (in_number_reg)
        begin
            push.tok0  = int_tok;
            push.count = makes ? 2'd2 : 2'd1;
        end
        else if (makes)
        begin
            push.count = 2'd1;
        end
        if (push.count == 2'd1)
        begin
            push.tok0.last_of_run = 1'b1;
        end
        if (push.count == 2'd2)
        begin
            push.tok1.last_of_run = 1'b1;
        end
        if (!proc)
        begin
            push.count = 2'd0;
        end

        in_number_next = in_number_reg;
        accum_next     = accum_reg;
        ovf_next       = ovf_reg;
        start_next     = start_reg;
        col_next       = col_reg;
        if (proc)
        begin
            if (digit)
            begin
                in_number_next = 1'b1;
                accum_next     = new_accum;
                ovf_next       = new_ovf;
                start_next     = new_start;
            end
            else
            begin
                in_number_next = 1'b0;
            end
            col_next = (&col_reg) ? col_reg : col_reg + 1'b1;
            if (item_reg.end_of_string)
            begin
                in_number_next = 1'b0;
                accum_next     = '0;
                ovf_next       = 1'b0;
                start_next     = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
                col_next       = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_number_reg <= 1'b0;
            accum_reg     <= '0;
            ovf_reg       <= 1'b0;
            start_reg     <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            col_reg       <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            in_number_reg <= in_number_next;
            accum_reg     <= accum_next;
            ovf_reg       <= ovf_next;
            start_reg     <= start_next;
            col_reg       <= col_next;
        end
    end

endmodule

FILE: src/aet_tok_fifo.sv
// Token queue: takes up to two tokens per cycle, delivers one per transaction.
`timescale 1ns / 1ps

module aet_tok_fifo
    import aet_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   space_ok,
    output logic   token_valid,
    input  logic   token_ready,
    output token_t token
);

    token_t              mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PTR_BITS-1:0] wr_plus1;
    logic                pop;

    assign token_valid = cnt_reg != '0;
    assign token       = mem_reg[rd_reg];
    assign pop         = token_valid && token_ready;
    assign space_ok    = cnt_reg <= CNT_BITS'(FIFO_DEPTH - 2);
    assign wr_plus1    = wr_reg + 1'b1;

    always_comb
    begin
        wr_next  = wr_reg + PTR_BITS'(push.count);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= push.tok0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_plus1] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: src/arith_expression_tokenizer.sv
// Top level: arithmetic expression tokenizer.
//
// Usage: one byte of an expression string enters per transaction on the item
// channel (item_valid / item_ready, payload item.ch and item.end_of_string).
// Tokens leave on the token channel (token_valid / token_ready), one per
// transaction, in string order; last_of_run marks the final token of a byte.
// Spaces make no token; a byte that closes a digit run makes up to two.
// Path: a byte is registered, then processed into the token queue when the
// queue has room; its first token is then visible at the queue output.
// Throughput: one byte per cycle while bytes give one token or none and the
// receiver keeps up; a two-token byte needs two single-port output transfers.
// The byte register is processed only when the four-entry token queue has
// room for two tokens; a stalled receiver fills the queue and then drops
// item_ready. Reset clears the digit run, the column (back to 1) and the queue.
`timescale 1ns / 1ps

module arith_expression_tokenizer
    import aet_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_ready,
    input  item_t  item,
    output logic   token_valid,
    input  logic   token_ready,
    output token_t token
);

    push_t push;
    logic  space_ok;

    aet_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .space_ok   (space_ok),
        .push       (push)
    );

    aet_tok_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .space_ok    (space_ok),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

endmodule
